FILE: rtl/core/input_capture_frequency_meter_macros.svh
// ---------------------------------------------------------------------------
// input_capture_frequency_meter assertion macros
// clocked assertion helpers, empty when synthesized
// ---------------------------------------------------------------------------
`ifndef INPUT_CAPTURE_FREQUENCY_METER_MACROS_SVH
`define INPUT_CAPTURE_FREQUENCY_METER_MACROS_SVH

`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define ICFM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequence holds in the cycle after the antecedent
`define ICFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ICFM_ASSERT(label, clk, rst_n, prop, msg)
`define ICFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/core/icfm_pkg.sv
// ---------------------------------------------------------------------------
// icfm_pkg
// shared widths, register indexes, states and control structs
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package icfm_pkg;

    localparam int COUNTER_BITS = 16;

    localparam int CAP_W     = 16;
    localparam int FREQ_W    = 32;
    localparam int SPAN_W    = 17;
    localparam int TALLY_W   = 16;
    localparam int PROD_W    = TALLY_W + SPAN_W;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_STEPS = FREQ_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_FREQ    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_SPAN = CFG_IDX_W'(1);

    localparam logic [FREQ_W-1:0]  CLOCK_FREQ_RESET    = FREQ_W'(45000000);
    localparam logic [SPAN_W-1:0]  OVERFLOW_SPAN_RESET = SPAN_W'(65536);
    localparam logic [TALLY_W-1:0] TALLY_MAX           = '1;

    function automatic logic [CAP_W-1:0] count_mask();
        if (COUNTER_BITS >= CAP_W) begin
            return '1;
        end else begin
            return CAP_W'((64'd1 << COUNTER_BITS) - 64'd1);
        end
    endfunction

    localparam logic [CAP_W-1:0] CAP_MASK = count_mask();

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELAPSED,
        ST_CHECK,
        ST_DIVIDE,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic accept_tick;
        logic accept_first;
        logic load_mul;
        logic load_elapsed;
        logic div_start;
        logic div_step;
        logic load_result;
    } t_cmd;

    typedef struct packed {
        logic elapsed_zero;
    } t_stat;

endpackage

FILE: rtl/core/icfm_ctrl.sv
// ---------------------------------------------------------------------------
// icfm_ctrl
// sequencer: edge phase, elapsed and divide steps, output word handshake
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module icfm_ctrl import icfm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_mode,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);

    t_state            r_state, n_state;
    logic              r_second, n_second;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              w_accept;
    logic              w_out_free;
    logic              w_last_step;

    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_last_step = (r_step == STEP_W'(DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && !i_mode && r_second) begin
                    n_state = ST_ELAPSED;
                end
            end
            ST_ELAPSED: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_stat.elapsed_zero ? ST_PUSH : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (w_last_step) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept_tick  = w_accept && i_mode;
                o_cmd.accept_first = w_accept && !i_mode && !r_second;
                o_cmd.load_mul     = w_accept && !i_mode && r_second;
            end
            ST_ELAPSED: begin
                o_cmd.load_elapsed = 1'b1;
            end
            ST_CHECK: begin
                o_cmd.div_start = !i_stat.elapsed_zero;
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
            end
            ST_PUSH: begin
                o_cmd.load_result = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_second = r_second;
        if (o_cmd.accept_first) begin
            n_second = 1'b1;
        end else if (o_cmd.load_mul) begin
            n_second = 1'b0;
        end

        n_step = r_step;
        if (o_cmd.div_start) begin
            n_step = '0;
        end else if (o_cmd.div_step) begin
            n_step = r_step + STEP_W'(1);
        end

        n_out_valid = r_out_valid;
        if (o_cmd.load_result) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_second    <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_second    <= n_second;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/icfm_divider.sv
// ---------------------------------------------------------------------------
// icfm_divider
// restoring divider, one quotient bit per step
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module icfm_divider import icfm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_start,
    input  logic              i_step,
    input  logic [FREQ_W-1:0] i_dividend,
    input  logic [FREQ_W-1:0] i_divisor,
    output logic [FREQ_W-1:0] o_quotient
);

    logic [FREQ_W-1:0] r_rem, n_rem;
    logic [FREQ_W-1:0] r_quo, n_quo;
    logic [FREQ_W-1:0] r_div, n_div;
    logic [FREQ_W:0]   w_trial;

    // partial remainder shifted up by one dividend bit, minus divisor
    assign w_trial = {r_rem, r_quo[FREQ_W-1]} - {1'b0, r_div};

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        n_div = r_div;
        if (i_start) begin
            n_rem = '0;
            n_quo = i_dividend;
            n_div = i_divisor;
        end else if (i_step) begin
            if (!w_trial[FREQ_W]) begin
                n_rem = w_trial[FREQ_W-1:0];
                n_quo = {r_quo[FREQ_W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[FREQ_W-2:0], r_quo[FREQ_W-1]};
                n_quo = {r_quo[FREQ_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_quotient = r_quo;

endmodule

FILE: rtl/core/icfm_datapath.sv
// ---------------------------------------------------------------------------
// icfm_datapath
// config registers, reference and tally, elapsed count, divider, result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module icfm_datapath import icfm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [CAP_W-1:0]     i_capture_count,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FREQ_W-1:0]    i_cfg_data,
    output t_stat                o_stat,
    output logic [FREQ_W-1:0]    o_frequency_hz,
    output logic                 o_kept_previous
);

    logic [FREQ_W-1:0]  r_clock_freq;
    logic [SPAN_W-1:0]  r_span;
    logic [CAP_W-1:0]   r_ref;
    logic [TALLY_W-1:0] r_tally;
    logic [CAP_W-1:0]   r_cap;
    logic [PROD_W-1:0]  r_prod;
    logic [FREQ_W-1:0]  r_elapsed;
    logic [FREQ_W-1:0]  r_last;
    logic               r_kept;
    logic [CAP_W-1:0]   w_cap;
    logic [FREQ_W-1:0]  w_quotient;
    logic               w_keep;

    assign w_cap = i_capture_count & CAP_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_freq <= CLOCK_FREQ_RESET;
            r_span       <= OVERFLOW_SPAN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CLOCK_FREQ:    r_clock_freq <= i_cfg_data;
                CFG_OVERFLOW_SPAN: r_span       <= i_cfg_data[SPAN_W-1:0];
                default:           r_span       <= r_span;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref   <= '0;
            r_tally <= '0;
            r_last  <= '0;
        end else begin
            if (i_cmd.accept_tick && (r_tally != TALLY_MAX)) begin
                r_tally <= r_tally + TALLY_W'(1);
            end else if (i_cmd.accept_first) begin
                r_tally <= '0;
            end
            if (i_cmd.accept_first) begin
                r_ref <= w_cap;
            end
            if (i_cmd.load_result && !w_keep) begin
                r_last <= w_quotient;
            end
        end
    end

    // product registered first, then the modular sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_mul) begin
            r_cap  <= w_cap;
            r_prod <= PROD_W'(r_tally) * PROD_W'(r_span);
        end
        if (i_cmd.load_elapsed) begin
            r_elapsed <= FREQ_W'(r_cap) + FREQ_W'(r_prod) - FREQ_W'(r_ref);
        end
        if (i_cmd.load_result) begin
            r_kept <= w_keep;
        end
    end

    icfm_divider u_divider (
        .i_clk      (i_clk),
        .i_start    (i_cmd.div_start),
        .i_step     (i_cmd.div_step),
        .i_dividend (r_clock_freq),
        .i_divisor  (r_elapsed),
        .o_quotient (w_quotient)
    );

    // quotient is stale when the divide was skipped, elapsed zero covers it
    assign w_keep = o_stat.elapsed_zero || (w_quotient == '0);

    assign o_stat.elapsed_zero = (r_elapsed == '0);
    assign o_frequency_hz      = r_last;
    assign o_kept_previous     = r_kept;

endmodule

FILE: rtl/core/input_capture_frequency_meter.sv
// ---------------------------------------------------------------------------
// input_capture_frequency_meter
// reciprocal frequency meter fed by timer capture and overflow events
// ---------------------------------------------------------------------------
// Overflow ticks and first capture edges leave the input ready and give no
// word. A capture edge that closes a pair gives one word (frequency and kept
// flag) and the input is not accepted again until its steps are done: the
// registered tally-span product, the elapsed sum and the zero check, the
// bit-serial restoring divider (one quotient bit a cycle), then loading the
// result; a zero elapsed count skips the divider. The result sits in an
// output register, so the next items are taken while it waits; a further
// closing edge holds in its final state until that word is taken.
// Configuration writes are registered and belong in idle time.
`timescale 1ns / 1ps
`include "input_capture_frequency_meter_macros.svh"

module input_capture_frequency_meter import icfm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_mode,
    input  logic [CAP_W-1:0]     i_capture_count,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [FREQ_W-1:0]    o_frequency_hz,
    output logic                 o_kept_previous,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FREQ_W-1:0]    i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    icfm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    icfm_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_capture_count (i_capture_count),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_stat          (w_stat),
        .o_frequency_hz  (o_frequency_hz),
        .o_kept_previous (o_kept_previous)
    );

    // at most one datapath command per cycle
    `ICFM_ASSERT(a_cmd_onehot, i_clk, i_rst_n, $onehot0(w_cmd), "datapath commands overlap")

    // a capture edge that closes a pair blocks the input while its result is worked out
    `ICFM_ASSERT_NEXT(a_busy_after_edge, i_clk, i_rst_n, w_cmd.load_mul, !o_in_ready, "input taken during divide")

    // loading a result always presents a word
    `ICFM_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, w_cmd.load_result, o_out_valid, "result loaded without word valid")

endmodule

FILE: sim/input_capture_frequency_meter_tb.sv
// ---------------------------------------------------------------------------
// input_capture_frequency_meter_tb
// self-checking bench: a short table of edge and tick events, then random
// capture sequences under several clock and span settings; every reading is
// compared field by field with a behavioral model of the meter (fixed table
// entries with their own values), with random input gaps and output stalls
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module input_capture_frequency_meter_tb;
    import icfm_pkg::*;

    localparam logic MODE_CAPTURE = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_LIMIT    = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 60;
    localparam int NUM_SETTINGS  = 8;
    localparam int NUM_PROBES    = 18;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic              kept;
    } t_reading;

    typedef struct packed {
        logic              mode;
        logic [CAP_W-1:0]  cap;
        logic              fixed;
        logic [FREQ_W-1:0] freq;
        logic              kept;
    } t_probe;

    typedef struct packed {
        logic [FREQ_W-1:0] clock_hz;
        logic [FREQ_W-1:0] span;
    } t_setting;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_mode = MODE_CAPTURE;
    logic [CAP_W-1:0]     i_capture_count = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [FREQ_W-1:0]    o_frequency_hz;
    logic                 o_kept_previous;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_CLOCK_FREQ;
    logic [FREQ_W-1:0]    i_cfg_data = '0;

    input_capture_frequency_meter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_capture_count(i_capture_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frequency_hz (o_frequency_hz),
        .o_kept_previous(o_kept_previous),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // meter model state and its copy of the registers
    logic [FREQ_W-1:0]  model_clock_hz = CLOCK_FREQ_RESET;
    logic [SPAN_W-1:0]  model_span = OVERFLOW_SPAN_RESET;
    logic               second_pending = 1'b0;
    logic [CAP_W-1:0]   ref_count = '0;
    logic [TALLY_W-1:0] tally = '0;
    logic [FREQ_W-1:0]  last_freq = '0;

    t_reading pending_readings[$];
    int       mismatch_count = 0;
    int       idle_cycles = 0;
    int       burst_left = 0;
    int       burst_gap = 0;
    int       stall_left = 0;
    int       stall_mode = 0;

    t_probe   probes [NUM_PROBES];
    t_setting settings [NUM_SETTINGS];

    function automatic void predict_reading(input logic m, input logic [CAP_W-1:0] c,
                                            output logic produced, output t_reading r);
        logic [CAP_W-1:0]  cap;
        logic [63:0]       total;
        logic [FREQ_W-1:0] elapsed;
        logic [FREQ_W-1:0] quot;
        cap = c & CAP_MASK;
        produced = 1'b0;
        r = '0;
        quot = '0;
        if (m == MODE_TICK) begin
            if (tally != TALLY_MAX) begin
                tally = tally + 1'b1;
            end
            return;
        end
        if (!second_pending) begin
            ref_count = cap;
            tally = '0;
            second_pending = 1'b1;
            return;
        end
        second_pending = 1'b0;
        total = 64'(cap) + 64'(tally) * 64'(model_span);
        elapsed = FREQ_W'(total - 64'(ref_count));
        if (elapsed != '0) begin
            quot = model_clock_hz / elapsed;
        end
        if (quot != '0) begin
            last_freq = quot;
        end
        r.freq = last_freq;
        r.kept = (quot == '0);
        produced = 1'b1;
    endfunction

    // send one word, then maybe close the burst with a gap
    task automatic feed(input logic m, input logic [CAP_W-1:0] c, input logic fixed,
                        input t_reading typed);
        logic     produced;
        t_reading r;
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_capture_count <= c;
        do @(posedge i_clk); while (!o_in_ready);
        predict_reading(m, c, produced, r);
        if (produced) begin
            pending_readings.push_back(fixed ? typed : r);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) < 2) begin
                burst_left = $urandom_range(50, 150);
                burst_gap = 0;
            end else begin
                burst_left = $urandom_range(1, 12);
                burst_gap = $urandom_range(1, 12);
            end
            if (burst_gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (burst_gap) @(posedge i_clk);
            end
        end
    endtask

    // stop sending and let every reading come out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input t_setting s);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_CLOCK_FREQ;
        i_cfg_data <= s.clock_hz;
        @(posedge i_clk);
        i_cfg_index <= CFG_OVERFLOW_SPAN;
        i_cfg_data <= s.span;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_clock_hz = s.clock_hz;
        model_span = SPAN_W'(s.span);
    endtask

    task automatic run_random(input int item_count);
        int               sent;
        int               ticks;
        int               r;
        logic             paused;
        logic [CAP_W-1:0] ref_val;
        logic [CAP_W-1:0] cap_val;
        sent = 0;
        paused = 1'b0;
        while (sent < item_count) begin
            if (!paused && sent >= item_count / 2) begin
                drain();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 80) begin
                // line up on a first edge, then a well-formed measurement
                if (second_pending) begin
                    feed(MODE_CAPTURE, CAP_W'($urandom), 1'b0, '0);
                    sent++;
                end
                ref_val = CAP_W'($urandom);
                feed(MODE_CAPTURE, ref_val, 1'b0, '0);
                r = $urandom_range(0, 9);
                ticks = (r < 4) ? 0 : (r < 8) ? $urandom_range(1, 3) : $urandom_range(4, 40);
                repeat (ticks) feed(MODE_TICK, CAP_W'($urandom), 1'b0, '0);
                r = $urandom_range(0, 9);
                if (r < 5) begin
                    cap_val = CAP_W'($urandom);
                end else if (r < 8) begin
                    cap_val = ref_val + CAP_W'($urandom_range(1, 300));
                end else if (r < 9) begin
                    cap_val = ref_val;
                end else begin
                    cap_val = ref_val - CAP_W'($urandom_range(1, 50));
                end
                feed(MODE_CAPTURE, cap_val, 1'b0, '0);
                sent += ticks + 2;
            end else begin
                feed(logic'($urandom_range(0, 1)), CAP_W'($urandom), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // receiver: ready pattern changes mode when its random stall count runs out
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 64);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= logic'($urandom_range(0, 1));
            2: i_out_ready <= ($urandom_range(0, 7) == 0);
            default: i_out_ready <= (stall_left % 4 != 0);
        endcase
    end

    always @(posedge i_clk) begin : reading_check
        t_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected word: freq %0d kept %0d", o_frequency_hz,
                             o_kept_previous);
                end
            end else begin
                want = pending_readings.pop_front();
                if (want.freq !== o_frequency_hz || want.kept !== o_kept_previous) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("word mismatch: expected freq %0d kept %0d, got freq %0d kept %0d",
                                 want.freq, want.kept, o_frequency_hz, o_kept_previous);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        // mode, count, fixed, freq, kept
        probes[0]  = '{MODE_CAPTURE, 16'h0000, 1'b0, 32'd0,        1'b0};
        probes[1]  = '{MODE_CAPTURE, 16'h0000, 1'b1, 32'd0,        1'b1}; // zero elapsed
        probes[2]  = '{MODE_CAPTURE, 16'h0000, 1'b0, 32'd0,        1'b0};
        probes[3]  = '{MODE_CAPTURE, 16'h0001, 1'b1, 32'd45000000, 1'b0};
        probes[4]  = '{MODE_CAPTURE, 16'hFFFF, 1'b0, 32'd0,        1'b0};
        probes[5]  = '{MODE_TICK,    16'h1234, 1'b0, 32'd0,        1'b0};
        probes[6]  = '{MODE_CAPTURE, 16'h0000, 1'b1, 32'd45000000, 1'b0};
        probes[7]  = '{MODE_CAPTURE, 16'h0064, 1'b0, 32'd0,        1'b0};
        probes[8]  = '{MODE_CAPTURE, 16'h0032, 1'b1, 32'd45000000, 1'b1}; // capture below ref
        probes[9]  = '{MODE_TICK,    16'hFFFF, 1'b0, 32'd0,        1'b0};
        probes[10] = '{MODE_CAPTURE, 16'h0000, 1'b0, 32'd0,        1'b0};
        probes[11] = '{MODE_CAPTURE, 16'hFFFF, 1'b1, 32'd686,      1'b0};
        probes[12] = '{MODE_CAPTURE, 16'h0000, 1'b0, 32'd0,        1'b0};
        probes[13] = '{MODE_TICK,    16'h0000, 1'b0, 32'd0,        1'b0};
        probes[14] = '{MODE_TICK,    16'h5A5A, 1'b0, 32'd0,        1'b0};
        probes[15] = '{MODE_CAPTURE, 16'h8000, 1'b0, 32'd0,        1'b0};
        probes[16] = '{MODE_CAPTURE, 16'hAAAA, 1'b0, 32'd0,        1'b0};
        probes[17] = '{MODE_CAPTURE, 16'h5555, 1'b0, 32'd0,        1'b0};

        settings[0] = '{32'd1,            32'd0};
        settings[1] = '{32'hFFFF_FFFF,    32'd131071};
        settings[2] = '{32'd0,            32'd65536};     // zero clock, always kept
        settings[3] = '{32'd45000000,     32'hFFFF_FFFF}; // upper data bits dropped
        settings[4] = '{32'd1000000,      32'd1};
        settings[5] = '{FREQ_W'($urandom), FREQ_W'($urandom_range(0, 131071))};
        settings[6] = '{FREQ_W'($urandom_range(1, 100000)), FREQ_W'($urandom_range(0, 256))};
        settings[7] = '{32'd45000000,     32'd65536};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probes[k]) begin
            feed(probes[k].mode, probes[k].cap, probes[k].fixed,
                 '{probes[k].freq, probes[k].kept});
        end

        foreach (settings[k]) begin
            drain();
            apply_setting(settings[k]);
            run_random(PHASE_ITEMS);
        end

        drain();

        if (mismatch_count == 0 && pending_readings.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: input_capture_frequency_meter.f
+incdir+rtl/core
rtl/core/icfm_pkg.sv
rtl/core/icfm_ctrl.sv
rtl/core/icfm_divider.sv
rtl/core/icfm_datapath.sv
rtl/core/input_capture_frequency_meter.sv
sim/input_capture_frequency_meter_tb.sv
